// File: sv/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: sv/prd_pkg.sv
package prd_pkg;

    localparam int ID_W   = 16;
    localparam int WORD_W = 2 * ID_W;
    localparam int OCC_W  = 5;

    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP        = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_FIND       = 3'd4,
        OP_PEEK       = 3'd5,
        OP_LIST       = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT
    } state_t;

    // Logical index issued to the memory read port
    typedef enum logic [1:0] {
        RD_FRONT,
        RD_SCAN,
        RD_SHIFT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_BACK,
        WR_FRONT,
        WR_SHIFT
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        HEAD_HOLD,
        HEAD_INC,
        HEAD_DEC
    } head_op_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_RDATA,
        SRC_PEND
    } src_sel_t;

    typedef struct packed {
        logic     load;
        rd_sel_t  rd_sel;
        logic     step;
        wr_sel_t  wr_sel;
        cnt_op_t  cnt_op;
        head_op_t head_op;
        logic     pend_load;
        logic     emit;
        status_t  status;
        src_sel_t src;
        logic     last;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic in_range;
        logic pid_hit;
        logic gid_hit;
        logic pend_vld;
    } dp_sts_t;

    function automatic logic is_scan_op(input op_t op);
        return (op == OP_REMOVE) || (op == OP_FIND) || (op == OP_LIST);
    endfunction

endpackage

// File: sv/prd_ctrl.sv
module prd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        opcode,
    input  prd_pkg::dp_sts_t  sts,
    output prd_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import prd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = is_scan_op(op_t'(opcode)) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (!sts.in_range)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.op == OP_FIND && sts.pid_hit)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.op == OP_REMOVE && sts.pid_hit)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (!sts.in_range)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load      = 1'b0;
        cmd.rd_sel    = RD_FRONT;
        cmd.step      = 1'b0;
        cmd.wr_sel    = WR_NONE;
        cmd.cnt_op    = CNT_HOLD;
        cmd.head_op   = HEAD_HOLD;
        cmd.pend_load = 1'b0;
        cmd.emit      = 1'b0;
        cmd.status    = ST_OK;
        cmd.src       = SRC_ZERO;
        cmd.last      = 1'b1;
        busy          = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_EXEC:
            begin
                cmd.emit = 1'b1;
                case (sts.op)
                    OP_PUSH_BACK:
                    begin
                        if (sts.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_sel = WR_BACK;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    OP_PUSH_FRONT:
                    begin
                        if (sts.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_sel  = WR_FRONT;
                            cmd.head_op = HEAD_DEC;
                            cmd.cnt_op  = CNT_INC;
                        end
                    end
                    OP_POP:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.src     = SRC_RDATA;
                            cmd.head_op = HEAD_INC;
                            cmd.cnt_op  = CNT_DEC;
                        end
                    end
                    OP_PEEK:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.src = SRC_RDATA;
                        end
                    end
                    default:
                    begin
                        cmd.status = ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.rd_sel = RD_SCAN;
                if (!sts.in_range)
                begin
                    // end of queue: flush the held list entry or report a miss
                    cmd.emit = 1'b1;
                    if (sts.op == OP_LIST && sts.pend_vld)
                    begin
                        cmd.src = SRC_PEND;
                    end
                    else
                    begin
                        cmd.status = ST_NOT_FOUND;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                    case (sts.op)
                        OP_FIND:
                        begin
                            if (sts.pid_hit)
                            begin
                                cmd.emit = 1'b1;
                                cmd.src  = SRC_RDATA;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (sts.pid_hit)
                            begin
                                // hold the index: it becomes the first slot to refill
                                cmd.step   = 1'b0;
                                cmd.emit   = 1'b1;
                                cmd.src    = SRC_RDATA;
                                cmd.cnt_op = CNT_DEC;
                            end
                        end
                        OP_LIST:
                        begin
                            if (sts.gid_hit)
                            begin
                                cmd.pend_load = 1'b1;
                                cmd.emit      = sts.pend_vld;
                                cmd.src       = SRC_PEND;
                                cmd.last      = 1'b0;
                            end
                        end
                        default:
                        begin
                            cmd.step = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                cmd.rd_sel = RD_SHIFT;
                if (sts.in_range)
                begin
                    cmd.wr_sel = WR_SHIFT;
                    cmd.step   = 1'b1;
                end
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/prd_datapath.sv
module prd_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prd_pkg::dp_cmd_t              cmd,
    output prd_pkg::dp_sts_t              sts,
    input  logic [2:0]                    opcode,
    input  logic [prd_pkg::ID_W-1:0]      proc_id,
    input  logic [prd_pkg::ID_W-1:0]      group_id,
    output logic                          result_valid,
    output prd_pkg::status_t              status,
    output logic [prd_pkg::ID_W-1:0]      out_proc_id,
    output logic [prd_pkg::ID_W-1:0]      out_group_id,
    output logic [prd_pkg::OCC_W-1:0]     occupancy,
    output logic                          last
);
    import prd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int PW = SW + 1;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     chk_idx_reg;
    op_t               op_reg;
    logic [ID_W-1:0]   pid_reg;
    logic [ID_W-1:0]   gid_reg;
    logic [WORD_W-1:0] pend_reg;
    logic              pend_vld_reg;

    logic              res_vld_reg;
    status_t           res_status_reg;
    logic [WORD_W-1:0] res_word_reg;
    logic              res_last_reg;

    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     head_dec;
    logic [SW-1:0]     rd_log;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] res_word;

    // queue position -> memory slot, wrapping around the circular buffer
    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] head,
                                              input logic [SW-1:0] lg);
        logic [PW-1:0] sum;
        sum = PW'(head) + PW'(lg);
        if (sum >= PW'(DEPTH))
        begin
            sum = sum - PW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SCAN:  rd_log = SW'(chk_idx_reg) + SW'(1);
            RD_SHIFT: rd_log = SW'(chk_idx_reg) + SW'(2);
            default:  rd_log = '0;
        endcase
    end

    assign rd_addr = to_phys(head_reg, rd_log);

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = head_dec;
        wr_data = {gid_reg, pid_reg};
        case (cmd.wr_sel)
            WR_BACK:
            begin
                wr_addr = to_phys(head_reg, SW'(count_reg));
            end
            WR_FRONT:
            begin
                wr_addr = head_dec;
            end
            WR_SHIFT:
            begin
                wr_addr = to_phys(head_reg, SW'(chk_idx_reg));
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        case (cmd.head_op)
            HEAD_INC: head_next = head_inc;
            HEAD_DEC: head_next = head_dec;
            default:  head_next = head_reg;
        endcase
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            chk_idx_reg  <= '0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            res_vld_reg <= cmd.emit;
            if (cmd.load)
            begin
                chk_idx_reg  <= '0;
                pend_vld_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    chk_idx_reg <= chk_idx_reg + CW'(1);
                end
                if (cmd.pend_load)
                begin
                    pend_vld_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        case (cmd.src)
            SRC_RDATA: res_word = rdata_reg;
            SRC_PEND:  res_word = pend_reg;
            default:   res_word = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(opcode);
            pid_reg <= proc_id;
            gid_reg <= group_id;
        end
        if (cmd.pend_load)
        begin
            pend_reg <= rdata_reg;
        end
        if (cmd.emit)
        begin
            res_status_reg <= cmd.status;
            res_word_reg   <= res_word;
            res_last_reg   <= cmd.last;
        end
    end

    assign sts.op       = op_reg;
    assign sts.full     = (count_reg == CW'(DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.in_range = (chk_idx_reg < count_reg);
    assign sts.pid_hit  = (rdata_reg[ID_W-1:0] == pid_reg);
    assign sts.gid_hit  = (rdata_reg[WORD_W-1:ID_W] == gid_reg);
    assign sts.pend_vld = pend_vld_reg;

    assign result_valid = res_vld_reg;
    assign status       = res_status_reg;
    assign out_proc_id  = res_word_reg[ID_W-1:0];
    assign out_group_id = res_word_reg[WORD_W-1:ID_W];
    assign occupancy    = OCC_W'(count_reg);
    assign last         = res_last_reg;

endmodule

// File: sv/process_ready_deque.sv
// Ordered queue of up to DEPTH process entries (process id, group id) in a
// circular buffer held in a single-port-read memory. A transaction is taken
// when start is high and busy is low; busy stays high until the final result
// has been issued, and for a remove until the later entries have moved up.
// Results come out on result_valid, one cycle each, with last on the final
// one, and cannot be stalled. Push, pop, peek and the unused opcode give
// their result from the EXEC state, through the result register. Find and
// list walk the queue one entry per cycle through the memory read port.
// Remove walks to the match and reports it, then moves each later entry up
// one slot at one entry per cycle with busy still high; the next
// transaction is taken only once busy has fallen again.
// No clearing pass follows reset.
`include "assert_macros.svh"

module process_ready_deque #(
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                opcode,
    input  logic [prd_pkg::ID_W-1:0]  proc_id,
    input  logic [prd_pkg::ID_W-1:0]  group_id,
    output logic                      result_valid,
    output prd_pkg::status_t          status,
    output logic [prd_pkg::ID_W-1:0]  out_proc_id,
    output logic [prd_pkg::ID_W-1:0]  out_group_id,
    output logic [prd_pkg::OCC_W-1:0] occupancy,
    output logic                      last
);
    import prd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    err_res_bad;

    prd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    prd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .proc_id      (proc_id),
        .group_id     (group_id),
        .result_valid (result_valid),
        .status       (status),
        .out_proc_id  (out_proc_id),
        .out_group_id (out_group_id),
        .occupancy    (occupancy),
        .last         (last)
    );

    assign err_res_bad = result_valid && (status != ST_OK)
                         && ((out_proc_id != '0) || (out_group_id != '0) || !last);

    `ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "accepted transaction did not raise busy")

    `ASSERT_CLK(a_more_busy, result_valid && !last |-> busy, "busy low while results remain")

    `ASSERT_NEVER(a_err_fields, err_res_bad, "error result carries entry data or is not last")

endmodule
